/* hw/rtl/rdc_pkg.sv */
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int OP_W    = 4;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int SLOT_W  = 8;
    localparam int CAP_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_ADD        = 4'd0,
        OP_READ_AT    = 4'd1,
        OP_READ_FIRST = 4'd2,
        OP_READ_LAST  = 4'd3,
        OP_READ_NEXT  = 4'd4,
        OP_POP_BACK   = 4'd5,
        OP_POP_FRONT  = 4'd6,
        OP_REWIND     = 4'd7,
        OP_CLEAR      = 4'd8,
        OP_STATUS     = 4'd9
    } rdc_op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_RESP
    } rdc_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

/* hw/rtl/rdc_if.sv */
`timescale 1ns / 1ps

interface rdc_in_if import rdc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
    logic               overwrite;
    logic [INDEX_W-1:0] index;

    modport source (output valid, output operation, output value, output overwrite,
                    output index, input ready);
    modport sink (input valid, input operation, input value, input overwrite,
                  input index, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [VALUE_W-1:0] data;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  head_index;
    logic [SLOT_W-1:0]  tail_index;
    logic               cursor_valid;
    logic               cursor_at_tail;

    modport source (output valid, output ok, output data, output count, output head_index,
                    output tail_index, output cursor_valid, output cursor_at_tail,
                    input ready);
    modport sink (input valid, input ok, input data, input count, input head_index,
                  input tail_index, input cursor_valid, input cursor_at_tail,
                  output ready);
endinterface

interface rdc_cfg_if import rdc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rdc_store.sv */
`timescale 1ns / 1ps

module rdc_store import rdc_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int ADDR_W  = 8,
    parameter int STORE_W = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mem_ctl_t           ctl,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [STORE_W-1:0] wdata,
    output logic [STORE_W-1:0] rdata,
    output logic               init_done
);

    logic [STORE_W-1:0] mem [ENTRIES];
    logic [STORE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  sweep_reg;
    logic [ADDR_W-1:0]  sweep_next;
    logic               done_reg;
    logic               done_next;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [STORE_W-1:0] wr_data;

    // The store is zeroed one entry per cycle after reset.
    always_comb
    begin
        sweep_next = sweep_reg;
        done_next  = done_reg;
        if (!done_reg)
        begin
            if (sweep_reg == ADDR_W'(ENTRIES - 1))
            begin
                done_next = 1'b1;
            end
            else
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        wr_en   = ctl.wr_en || !done_reg;
        wr_addr = done_reg ? addr : sweep_reg;
        wr_data = done_reg ? wdata : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata     = rdata_reg;
    assign init_done = done_reg;

endmodule

/* hw/rtl/rdc_ctrl.sv */
`timescale 1ns / 1ps

module rdc_ctrl import rdc_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int ADDR_W  = 8,
    parameter int CNT_W   = 9,
    parameter int STORE_W = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    rdc_in_if.sink             req,
    rdc_out_if.source          rsp,
    rdc_cfg_if.sink            cfg,
    input  logic               init_done,
    output mem_ctl_t           mem_ctl,
    output logic [ADDR_W-1:0]  mem_addr,
    output logic [STORE_W-1:0] mem_wdata,
    input  logic [STORE_W-1:0] mem_rdata
);

    rdc_state_t         state_reg;
    rdc_state_t         state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   cap_next;
    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ADDR_W-1:0]  cursor_reg;
    logic [ADDR_W-1:0]  cursor_next;
    logic               live_reg;
    logic               live_next;
    logic               pend_ok_reg;
    logic               pend_ok_next;
    logic               pend_read_reg;
    logic               pend_read_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_ok_reg;
    logic               out_ok_next;
    logic [VALUE_W-1:0] out_data_reg;
    logic [VALUE_W-1:0] out_data_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;
    logic [SLOT_W-1:0]  out_head_reg;
    logic [SLOT_W-1:0]  out_head_next;
    logic [SLOT_W-1:0]  out_tail_reg;
    logic [SLOT_W-1:0]  out_tail_next;
    logic               out_cv_reg;
    logic               out_cv_next;
    logic               out_cat_reg;
    logic               out_cat_next;

    logic               accept;
    logic               load_out;
    logic               cnt_zero;
    logic [CNT_W-1:0]   eff_cap;
    logic [ADDR_W-1:0]  tail_cur;
    logic [ADDR_W-1:0]  head_base;
    logic [ADDR_W-1:0]  cursor_inc;
    logic [ADDR_W-1:0]  add_slot;
    logic               idx_ok;

    function automatic logic [ADDR_W-1:0] wrap_slot(input logic [CNT_W:0] x,
                                                    input logic [CNT_W-1:0] c);
        logic [CNT_W:0] cx;
        logic [CNT_W:0] r;
        cx = {1'b0, c};
        r  = (x >= cx) ? x - cx : x;
        return r[ADDR_W-1:0];
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CAP_W'(ENTRIES))
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign cnt_zero   = (count_reg == '0);
    assign tail_cur   = cnt_zero ? '0
                      : wrap_slot((CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg)
                                  - (CNT_W+1)'(1), eff_cap);
    assign head_base  = cnt_zero ? '0 : head_reg;
    assign add_slot   = wrap_slot((CNT_W+1)'(head_base) + (CNT_W+1)'(count_reg), eff_cap);
    assign cursor_inc = wrap_slot((CNT_W+1)'(cursor_reg) + (CNT_W+1)'(1), eff_cap);
    assign idx_ok     = ((CNT_W+INDEX_W)'(req.index) < (CNT_W+INDEX_W)'(eff_cap));

    assign accept   = req.valid && req.ready;
    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // A configuration write takes precedence over a new transaction and waits
    // while a transaction is in flight.
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE) && !cfg.valid;
        cfg.ready = (state_reg != ST_RESP);
    end

    always_comb
    begin
        cap_next       = cap_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        live_next      = live_reg;
        pend_ok_next   = pend_ok_reg;
        pend_read_next = pend_read_reg;
        mem_ctl        = '0;
        mem_addr       = '0;
        mem_wdata      = STORE_W'(req.value);

        if (cfg.valid && cfg.ready)
        begin
            cap_next   = cfg.data;
            count_next = '0;
            head_next  = '0;
            live_next  = 1'b0;
        end
        else if (accept)
        begin
            pend_ok_next   = 1'b0;
            pend_read_next = 1'b0;
            case (req.operation)
                OP_ADD:
                begin
                    head_next = head_base;
                    if ((count_reg < eff_cap) || req.overwrite)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = add_slot;
                        if (count_reg >= eff_cap)
                        begin
                            head_next = wrap_slot((CNT_W+1)'(head_base) + (CNT_W+1)'(1),
                                                  eff_cap);
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        pend_ok_next = 1'b1;
                    end
                end
                OP_READ_AT:
                begin
                    if (idx_ok)
                    begin
                        cursor_next    = ADDR_W'(req.index);
                        live_next      = 1'b1;
                        mem_ctl.rd_en  = 1'b1;
                        mem_addr       = ADDR_W'(req.index);
                        pend_ok_next   = 1'b1;
                        pend_read_next = 1'b1;
                    end
                end
                OP_READ_FIRST:
                begin
                    if (!cnt_zero)
                    begin
                        cursor_next    = head_reg;
                        live_next      = 1'b1;
                        mem_ctl.rd_en  = 1'b1;
                        mem_addr       = head_reg;
                        pend_ok_next   = 1'b1;
                        pend_read_next = 1'b1;
                    end
                end
                OP_READ_LAST:
                begin
                    if (!cnt_zero)
                    begin
                        mem_ctl.rd_en  = 1'b1;
                        mem_addr       = tail_cur;
                        pend_ok_next   = 1'b1;
                        pend_read_next = 1'b1;
                    end
                end
                OP_READ_NEXT:
                begin
                    if (!cnt_zero)
                    begin
                        if (!live_reg)
                        begin
                            cursor_next    = head_reg;
                            live_next      = 1'b1;
                            mem_ctl.rd_en  = 1'b1;
                            mem_addr       = head_reg;
                            pend_ok_next   = 1'b1;
                            pend_read_next = 1'b1;
                        end
                        else if (cursor_reg == tail_cur)
                        begin
                            live_next = 1'b0;
                        end
                        else
                        begin
                            cursor_next    = cursor_inc;
                            mem_ctl.rd_en  = 1'b1;
                            mem_addr       = cursor_inc;
                            pend_ok_next   = 1'b1;
                            pend_read_next = 1'b1;
                        end
                    end
                end
                OP_POP_BACK:
                begin
                    if (!cnt_zero)
                    begin
                        cursor_next    = tail_cur;
                        live_next      = 1'b1;
                        mem_ctl.rd_en  = 1'b1;
                        mem_addr       = tail_cur;
                        count_next     = count_reg - CNT_W'(1);
                        pend_ok_next   = 1'b1;
                        pend_read_next = 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            live_next = 1'b0;
                        end
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!cnt_zero)
                    begin
                        mem_ctl.rd_en  = 1'b1;
                        mem_addr       = head_reg;
                        count_next     = count_reg - CNT_W'(1);
                        pend_ok_next   = 1'b1;
                        pend_read_next = 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            live_next = 1'b0;
                        end
                        else
                        begin
                            head_next = wrap_slot((CNT_W+1)'(head_reg) + (CNT_W+1)'(1),
                                                  eff_cap);
                        end
                    end
                end
                OP_REWIND:
                begin
                    live_next    = 1'b0;
                    pend_ok_next = 1'b1;
                end
                OP_CLEAR:
                begin
                    count_next   = '0;
                    head_next    = '0;
                    live_next    = 1'b0;
                    pend_ok_next = 1'b1;
                end
                OP_STATUS:
                begin
                    pend_ok_next = 1'b1;
                end
                default:
                begin
                    pend_ok_next = 1'b0;
                end
            endcase
        end
    end

    // The status fields are taken from the state registers, which already hold
    // the outcome of the transaction in flight.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_head_next  = out_head_reg;
        out_tail_next  = out_tail_reg;
        out_cv_next    = out_cv_reg;
        out_cat_next   = out_cat_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = pend_ok_reg;
            out_data_next  = pend_read_reg ? VALUE_W'(mem_rdata) : '0;
            out_count_next = COUNT_W'(count_reg);
            out_head_next  = cnt_zero ? '0 : SLOT_W'(head_reg);
            out_tail_next  = SLOT_W'(tail_cur);
            out_cv_next    = live_reg;
            out_cat_next   = live_reg && !cnt_zero && (cursor_reg == tail_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            live_reg      <= 1'b0;
            pend_ok_reg   <= 1'b0;
            pend_read_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            live_reg      <= live_next;
            pend_ok_reg   <= pend_ok_next;
            pend_read_reg <= pend_read_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ok_reg    <= out_ok_next;
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_head_reg  <= out_head_next;
        out_tail_reg  <= out_tail_next;
        out_cv_reg    <= out_cv_next;
        out_cat_reg   <= out_cat_next;
    end

    always_comb
    begin
        rsp.valid          = out_valid_reg;
        rsp.ok             = out_ok_reg;
        rsp.data           = out_data_reg;
        rsp.count          = out_count_reg;
        rsp.head_index     = out_head_reg;
        rsp.tail_index     = out_tail_reg;
        rsp.cursor_valid   = out_cv_reg;
        rsp.cursor_at_tail = out_cat_reg;
    end

endmodule

/* hw/rtl/ring_deque_with_read_cursor.sv */
`timescale 1ns / 1ps
// Results: an accepted transaction moves the controller to ST_RESP, which loads the
// single-port store's registered read into the output registers once they are free.
// None is taken in ST_RESP; the next is taken while a result waits on the output.
// Reset: control state clears at once, then the store is zeroed one entry per cycle
// over all min(DEPTH, 511) entries; transactions are accepted once ST_INIT is left.

module ring_deque_with_read_cursor import rdc_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    rdc_in_if.sink     req,
    rdc_out_if.source  rsp,
    rdc_cfg_if.sink    cfg
);

    localparam int ENTRIES = (DEPTH < 511) ? DEPTH : 511;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  mem_addr;
    logic [STORE_W-1:0] mem_wdata;
    logic [STORE_W-1:0] mem_rdata;
    logic               init_done;

    rdc_ctrl #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W),
        .CNT_W   (CNT_W),
        .STORE_W (STORE_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .init_done (init_done),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    rdc_store #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W),
        .STORE_W (STORE_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mem_ctl),
        .addr      (mem_addr),
        .wdata     (mem_wdata),
        .rdata     (mem_rdata),
        .init_done (init_done)
    );

endmodule

/* tb/ring_deque_with_read_cursor_test.sv */
`timescale 1ns / 1ps

module ring_deque_with_read_cursor_test;
    import rdc_pkg::*;

    localparam int DEPTH = 256;
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd10;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] data;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  head_index;
        logic [SLOT_W-1:0]  tail_index;
        logic               cursor_valid;
        logic               cursor_at_tail;
    } reply_t;

    typedef enum int {
        RX_STEADY,
        RX_PATTERN,
        RX_RANDOM
    } rx_mode_t;

    class deque_tracker;
        logic [VALUE_W-1:0] slots [0:DEPTH-1];
        int                 head;
        int                 cnt;
        int                 cur;
        bit                 cur_live;
        logic [CAP_W-1:0]   cap_reg;
        reply_t             replies_due [$];
        int                 faults;

        function new();
            foreach (slots[i])
            begin
                slots[i] = '0;
            end
            head = 0;
            cnt = 0;
            cur = 0;
            cur_live = 1'b0;
            cap_reg = CAP_RESET;
            faults = 0;
        endfunction

        function int eff_cap();
            if (cap_reg == 0)
            begin
                return 1;
            end
            if (cap_reg > DEPTH)
            begin
                return DEPTH;
            end
            return cap_reg;
        endfunction

        function int wrap_slot(int x, int c);
            int r;
            r = (x >= c) ? x - c : x;
            return (r < DEPTH) ? r : 0;
        endfunction

        function int tail_slot(int c);
            if (cnt == 0)
            begin
                return 0;
            end
            return wrap_slot(head + cnt - 1, c);
        endfunction

        function void empty_out();
            cnt = 0;
            head = 0;
            cur_live = 1'b0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            cap_reg = v;
            empty_out();
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void apply_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val, logic ovw,
                               logic [INDEX_W-1:0] idx);
            int     c;
            int     s;
            int     t;
            reply_t r;
            c = eff_cap();
            r = '0;
            case (op)
                OP_ADD:
                begin
                    if (cnt == 0)
                    begin
                        head = 0;
                    end
                    if (cnt < c || ovw)
                    begin
                        s = wrap_slot(head + cnt, c);
                        slots[s] = val;
                        if (cnt >= c)
                        begin
                            head = wrap_slot(head + 1, c);
                        end
                        else
                        begin
                            cnt++;
                        end
                        r.ok = 1'b1;
                    end
                end
                OP_READ_AT:
                begin
                    if (idx < c)
                    begin
                        cur = idx;
                        cur_live = 1'b1;
                        r.data = slots[idx];
                        r.ok = 1'b1;
                    end
                end
                OP_READ_FIRST:
                begin
                    if (cnt != 0)
                    begin
                        cur = head;
                        cur_live = 1'b1;
                        r.data = slots[head];
                        r.ok = 1'b1;
                    end
                end
                OP_READ_LAST:
                begin
                    if (cnt != 0)
                    begin
                        r.data = slots[tail_slot(c)];
                        r.ok = 1'b1;
                    end
                end
                OP_READ_NEXT:
                begin
                    if (cnt != 0)
                    begin
                        t = tail_slot(c);
                        if (!cur_live)
                        begin
                            cur = head;
                            cur_live = 1'b1;
                        end
                        else if (cur == t)
                        begin
                            cur_live = 1'b0;
                        end
                        else
                        begin
                            cur = wrap_slot(cur + 1, c);
                        end
                        if (cur_live)
                        begin
                            r.data = slots[cur];
                            r.ok = 1'b1;
                        end
                    end
                end
                OP_POP_BACK:
                begin
                    if (cnt != 0)
                    begin
                        t = tail_slot(c);
                        cur = t;
                        cur_live = 1'b1;
                        r.data = slots[t];
                        cnt--;
                        if (cnt == 0)
                        begin
                            empty_out();
                        end
                        r.ok = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (cnt != 0)
                    begin
                        r.data = slots[head];
                        cnt--;
                        if (cnt != 0)
                        begin
                            head = wrap_slot(head + 1, c);
                        end
                        else
                        begin
                            empty_out();
                        end
                        r.ok = 1'b1;
                    end
                end
                OP_REWIND:
                begin
                    cur_live = 1'b0;
                    r.ok = 1'b1;
                end
                OP_CLEAR:
                begin
                    empty_out();
                    r.ok = 1'b1;
                end
                OP_STATUS:
                begin
                    r.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            t = tail_slot(c);
            r.count = COUNT_W'(cnt);
            r.head_index = (cnt != 0) ? SLOT_W'(head) : '0;
            r.tail_index = SLOT_W'(t);
            r.cursor_valid = cur_live;
            r.cursor_at_tail = cur_live && cnt != 0 && cur == t;
            replies_due.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                begin
                    $display("%0t: result with no transaction outstanding", $realtime);
                end
                return;
            end
            want = replies_due.pop_front();
            if (got.ok !== want.ok || got.data !== want.data || got.count !== want.count ||
                got.head_index !== want.head_index || got.tail_index !== want.tail_index ||
                got.cursor_valid !== want.cursor_valid ||
                got.cursor_at_tail !== want.cursor_at_tail)
            begin
                faults++;
                if (faults <= REPORT_LIMIT)
                begin
                    $display("%0t: expected ok=%0d data=%h count=%0d head=%0d tail=%0d cv=%0d ct=%0d",
                             $realtime, want.ok, want.data, want.count, want.head_index,
                             want.tail_index, want.cursor_valid, want.cursor_at_tail);
                    $display("%0t: actual   ok=%0d data=%h count=%0d head=%0d tail=%0d cv=%0d ct=%0d",
                             $realtime, got.ok, got.data, got.count, got.head_index,
                             got.tail_index, got.cursor_valid, got.cursor_at_tail);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rdc_in_if  req_if ();
    rdc_out_if rsp_if ();
    rdc_cfg_if cfg_if ();

    ring_deque_with_read_cursor uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    deque_tracker tracker;
    int           quiet_cycles = 0;
    int           burst_left = 0;
    rx_mode_t     stall_mode = RX_STEADY;
    logic [15:0]  stall_pat = 16'hFFFF;
    logic [3:0]   stall_phase = '0;
    int           stall_timer = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_timer = $urandom_range(20, 80);
            stall_mode = rx_mode_t'($urandom_range(0, 2));
            stall_pat = 16'($urandom) | 16'h0101;
        end
        stall_timer--;
        case (stall_mode)
            RX_STEADY:
            begin
                rsp_if.ready <= 1'b1;
            end
            RX_PATTERN:
            begin
                rsp_if.ready <= stall_pat[stall_phase];
                stall_phase = stall_phase + 4'd1;
            end
            default:
            begin
                rsp_if.ready <= ($urandom_range(0, 9) >= 3);
            end
        endcase
    end

    always @(posedge clk)
    begin : monitor
        reply_t got;
        bit     moved;
        moved = 1'b0;
        if (rsp_if.valid && rsp_if.ready)
        begin
            got.ok = rsp_if.ok;
            got.data = rsp_if.data;
            got.count = rsp_if.count;
            got.head_index = rsp_if.head_index;
            got.tail_index = rsp_if.tail_index;
            got.cursor_valid = rsp_if.cursor_valid;
            got.cursor_at_tail = rsp_if.cursor_at_tail;
            tracker.check_reply(got);
            moved = 1'b1;
        end
        if (req_if.valid && req_if.ready)
        begin
            tracker.apply_op(req_if.operation, req_if.value, req_if.overwrite, req_if.index);
            moved = 1'b1;
        end
        if (cfg_if.valid && cfg_if.ready)
        begin
            tracker.set_capacity(cfg_if.data);
            moved = 1'b1;
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Every task that drives the block is entered and left at a falling edge.
    task automatic send(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val,
                        input logic ovw, input logic [INDEX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.value <= val;
        req_if.overwrite <= ovw;
        req_if.index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained(input int settle);
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained(4);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        int c;
        c = tracker.eff_cap();
        if ($urandom_range(0, 9) < 7)
        begin
            return INDEX_W'($urandom_range(0, (c > 255) ? 255 : c));
        end
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38) return OP_ADD;
        if (r < 48) return OP_READ_AT;
        if (r < 53) return OP_READ_FIRST;
        if (r < 58) return OP_READ_LAST;
        if (r < 70) return OP_READ_NEXT;
        if (r < 79) return OP_POP_BACK;
        if (r < 88) return OP_POP_FRONT;
        if (r < 92) return OP_REWIND;
        if (r < 94) return OP_CLEAR;
        if (r < 97) return OP_STATUS;
        return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    endfunction

    task automatic fill_up(input int extra);
        int n;
        n = tracker.eff_cap() + extra;
        repeat (n)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send(OP_READ_NEXT, rand_value(), 1'($urandom), rand_index());
            end
            send(OP_ADD, rand_value(), 1'($urandom), rand_index());
        end
    endtask

    task automatic run_random(input int n);
        int sent;
        int steps;
        sent = 0;
        while (sent < n)
        begin
            // A cursor walk from the head, long enough to run off the tail on short buffers.
            if ($urandom_range(0, 9) == 0 && tracker.cnt > 0)
            begin
                steps = (tracker.cnt <= 10) ? tracker.cnt + 1 : $urandom_range(1, 10);
                send(OP_READ_FIRST, rand_value(), 1'($urandom), rand_index());
                repeat (steps) send(OP_READ_NEXT, rand_value(), 1'($urandom), rand_index());
                sent += steps + 1;
            end
            else
            begin
                send(rand_op(), rand_value(), 1'($urandom), rand_index());
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap_val, input int n, input bit fill_first);
        write_capacity(cap_val);
        if (fill_first)
        begin
            fill_up(3);
        end
        run_random(n);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = OP_STATUS;
        req_if.value = '0;
        req_if.overwrite = 1'b0;
        req_if.index = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        tracker = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Empty buffer at the reset capacity, then a short walk over three elements.
        send(OP_STATUS, '0, 1'b0, '0);
        send(OP_READ_FIRST, '0, 1'b0, '0);
        send(OP_READ_LAST, '0, 1'b0, '0);
        send(OP_READ_NEXT, '0, 1'b0, '0);
        send(OP_POP_BACK, '0, 1'b0, '0);
        send(OP_POP_FRONT, '0, 1'b0, '0);
        send(OP_READ_AT, '0, 1'b0, 8'd0);
        send(OP_READ_AT, '0, 1'b0, 8'd255);
        send(OP_ADD, '1, 1'b0, 8'd255);
        send(OP_ADD, '0, 1'b1, '0);
        send(OP_ADD, 32'hA5A5_5A5A, 1'b1, 8'hAA);
        send(OP_READ_FIRST, '0, 1'b0, '0);
        send(OP_READ_NEXT, '0, 1'b0, '0);
        send(OP_READ_NEXT, '0, 1'b0, '0);
        send(OP_READ_NEXT, '0, 1'b0, '0);
        send(OP_READ_NEXT, '0, 1'b0, '0);
        send(OP_READ_LAST, '0, 1'b0, '0);
        send(OP_POP_BACK, '0, 1'b0, '0);
        send(OP_REWIND, '0, 1'b0, '0);
        send(OP_POP_FRONT, '0, 1'b0, '0);
        send(OP_POP_FRONT, '0, 1'b0, '0);
        send(OP_ADD, 32'h1234_5678, 1'b0, 8'h55);
        send(OP_CLEAR, '0, 1'b0, '0);
        send(OP_UNDEF_LO, '1, 1'b1, '1);
        send(OP_UNDEF_HI, '1, 1'b1, '1);
        send(OP_STATUS, '0, 1'b0, '0);

        // A capacity of zero behaves as a single slot.
        write_capacity('0);
        send(OP_READ_AT, '0, 1'b0, 8'd0);
        send(OP_ADD, 32'h0000_0011, 1'b0, '0);
        send(OP_ADD, 32'h0000_0022, 1'b0, '0);
        send(OP_ADD, 32'h0000_0033, 1'b1, '0);
        send(OP_READ_AT, '0, 1'b0, 8'd1);
        send(OP_READ_AT, '0, 1'b0, 8'd255);
        send(OP_READ_NEXT, '0, 1'b0, '0);
        send(OP_POP_FRONT, '0, 1'b0, '0);
        send(OP_POP_BACK, '0, 1'b0, '0);

        run_phase(9'd3, 30, 1'b1);
        run_phase(9'd1, 20, 1'b1);
        run_phase(9'd511, 25, 1'b1);
        run_phase(9'd2, 20, 1'b1);
        run_phase(9'd257, 20, 1'b0);
        run_phase(9'd5, 30, 1'b1);
        run_phase(CAP_W'($urandom_range(4, 16)), 25, 1'b1);
        run_phase(9'd256, 15, 1'b0);

        wait_drained(8);
        if (tracker.faults == 0 && tracker.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_if.sv
hw/rtl/rdc_store.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/ring_deque_with_read_cursor.sv
tb/ring_deque_with_read_cursor_test.sv
